/* hw/rtl/atm_pkg.sv */
`timescale 1ns / 1ps

package atm_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_TOO_LONG   = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_MATCH      = 3'd3;
  localparam logic [2:0] ST_NO_MATCH   = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  localparam int ALPHABET_BITS = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] match_tag;
  } result_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/atm_ram.sv */
`timescale 1ns / 1ps

module atm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/atm_out_reg.sv */
`timescale 1ns / 1ps

module atm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atm_pkg::result_t  din,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] match_tag
  output logic [2:0]        out_tuser   // [2:0] status
);

  logic             valid_r;
  logic             valid_nxt;
  atm_pkg::result_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (push) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push && free) begin
      res_r <= din;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.match_tag;
  assign out_tuser  = res_r.status;

endmodule

/* hw/rtl/anchored_trie_matcher_top.sv */
`timescale 1ns / 1ps

// Case-insensitive anchored trie matcher.
// Input words carry an opcode on in_tuser (insert byte, search byte, clear),
// the byte, first flag, tag and resume flag on in_tdata and the last flag on
// in_tlast. Each word gives at most one result word: status on out_tuser and
// the matched pattern id on out_tdata.
// Insert bytes that are not last are buffered. A last insert byte commits the
// buffered pattern: per byte, the buffered byte comes back with a transition
// read, and a new edge then gets a lower-case write and an upper-case write;
// a too long or full pattern is answered without a commit.
// A search byte reads the transition memory and, on a match, also the tag
// memory; a byte whose walk goes on gives no result, and once the search is
// decided the remaining bytes are taken without a read.
// Reset and the clear opcode start a sweep that zeroes all STATES*256 entries
// of the transition memory, one entry per cycle; no word is accepted during it.
// A result sits in an output register; the next input word is accepted while
// it waits. When the receiver stalls and a new result is ready, the engine
// holds until the output register frees.
module anchored_trie_matcher_top #(
  parameter int STATES          = 256,
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] data_byte, [8] first, [24:9] tag, [25] resume
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] match_tag
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int EW    = SW + 1;
  localparam int NFW   = $clog2(STATES + 1);
  localparam int LW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int BAW   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int TAW   = SW + atm_pkg::ALPHABET_BITS;
  localparam int TDEP  = STATES * 256;
  localparam int CW    = ((NFW > LW) ? NFW : LW) + 1;

  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_CB_RD    = 4'd3;
  localparam logic [3:0] S_CT_EVAL  = 4'd4;
  localparam logic [3:0] S_CT_WR2   = 4'd5;
  localparam logic [3:0] S_TAG_WR   = 4'd6;
  localparam logic [3:0] S_SR_EVAL  = 4'd7;
  localparam logic [3:0] S_SR_TAG   = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;
  localparam logic [3:0] S_CLR_EMIT = 4'd10;

  logic [7:0]  in_byte;
  logic        in_first;
  logic [15:0] in_tag;
  logic        in_resume;

  assign in_byte   = in_tdata[7:0];
  assign in_first  = in_tdata[8];
  assign in_tag    = in_tdata[24:9];
  assign in_resume = in_tdata[25];

  logic [3:0]     state_r, state_nxt;
  logic [TAW-1:0] sweep_r, sweep_nxt;
  logic [NFW-1:0] nf_r, nf_nxt;
  logic [SW-1:0]  ss_r, ss_nxt;
  logic [SW-1:0]  walk_r, walk_nxt;
  logic           dec_r, dec_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [LW-1:0]  idx_r, idx_nxt;
  logic [SW-1:0]  st_r, st_nxt;
  logic [7:0]     b_r, b_nxt;
  logic [EW-1:0]  ent_r, ent_nxt;
  logic [15:0]    tag_r, tag_nxt;
  logic           last_r, last_nxt;
  atm_pkg::result_t res_r, res_nxt;

  // memory ports
  logic             tbl_we, tbl_re;
  logic [TAW-1:0]   tbl_waddr, tbl_raddr;
  logic [EW-1:0]    tbl_wdata, tbl_rdata;
  logic             tg_we, tg_re;
  logic [SW-1:0]    tg_waddr, tg_raddr;
  logic [15:0]      tg_rdata;
  logic             pb_we, pb_re;
  logic [BAW-1:0]   pb_waddr, pb_raddr;
  logic [7:0]       pb_rdata;

  logic out_push, out_free;

  atm_ram #(.DEPTH(TDEP), .WIDTH(EW), .AW(TAW)) u_trans (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  atm_ram #(.DEPTH(STATES), .WIDTH(16), .AW(SW)) u_tags (
    .clk   (clk),
    .we    (tg_we),
    .waddr (tg_waddr),
    .wdata (tag_r),
    .re    (tg_re),
    .raddr (tg_raddr),
    .rdata (tg_rdata)
  );

  atm_ram #(.DEPTH(MAX_PATTERN_LEN), .WIDTH(8), .AW(BAW)) u_pbuf (
    .clk   (clk),
    .we    (pb_we),
    .waddr (pb_waddr),
    .wdata (in_byte),
    .re    (pb_re),
    .raddr (pb_raddr),
    .rdata (pb_rdata)
  );

  atm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (out_push),
    .din        (res_r),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = (state_r == S_IDLE);

  logic           accept;
  logic [LW-1:0]  len_base;
  logic           ovf_base;
  logic [SW-1:0]  walk_base;
  logic           dec_base;
  logic [LW-1:0]  idx_inc;
  logic           idx_final;
  logic [CW-1:0]  need;
  logic           tbl_empty;
  logic [SW-1:0]  tbl_id;
  logic           tbl_flag;

  assign accept    = in_tvalid && in_tready;
  assign len_base  = in_first ? '0 : len_r;
  assign ovf_base  = in_first ? 1'b0 : ovf_r;
  assign walk_base = in_first ? (in_resume ? ss_r : '0) : walk_r;
  assign dec_base  = in_first ? 1'b0 : dec_r;
  assign idx_inc   = idx_r + LW'(1);
  assign idx_final = (idx_inc == len_r);
  assign need      = CW'(nf_r) + CW'(len_r);
  assign tbl_empty = (tbl_rdata == '0);
  assign tbl_id    = tbl_rdata[SW-1:0];
  assign tbl_flag  = tbl_rdata[SW];

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    nf_nxt    = nf_r;
    ss_nxt    = ss_r;
    walk_nxt  = walk_r;
    dec_nxt   = dec_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    b_nxt     = b_r;
    ent_nxt   = ent_r;
    tag_nxt   = tag_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = '0;
    tg_we     = 1'b0;
    tg_waddr  = st_r;
    tg_re     = 1'b0;
    tg_raddr  = tbl_id;
    pb_we     = 1'b0;
    pb_waddr  = len_base[BAW-1:0];
    pb_re     = 1'b0;
    pb_raddr  = idx_r[BAW-1:0];
    out_push  = 1'b0;

    unique case (state_r)
      S_SWEEP: begin
        tbl_we    = 1'b1;
        tbl_waddr = sweep_r;
        sweep_nxt = sweep_r + TAW'(1);
        if (sweep_r == TAW'(TDEP - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            atm_pkg::OP_INSERT: begin
              len_nxt = len_base;
              ovf_nxt = ovf_base;
              if (len_base < LW'(MAX_PATTERN_LEN)) begin
                pb_we   = 1'b1;
                len_nxt = len_base + LW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_tlast) begin
                tag_nxt   = in_tag;
                state_nxt = S_CHECK;
              end
            end
            atm_pkg::OP_SEARCH: begin
              walk_nxt = walk_base;
              dec_nxt  = dec_base;
              last_nxt = in_tlast;
              if (!dec_base) begin
                tbl_re    = 1'b1;
                tbl_raddr = {walk_base, in_byte};
                state_nxt = S_SR_EVAL;
              end
            end
            atm_pkg::OP_CLEAR: begin
              nf_nxt    = NFW'(1);
              ss_nxt    = '0;
              walk_nxt  = '0;
              dec_nxt   = 1'b0;
              len_nxt   = '0;
              ovf_nxt   = 1'b0;
              res_nxt   = '{status: atm_pkg::ST_CLEARED, match_tag: 16'h0};
              state_nxt = S_CLR_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        res_nxt.match_tag = 16'h0;
        if (ovf_r) begin
          res_nxt.status = atm_pkg::ST_TOO_LONG;
          len_nxt        = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_EMIT;
        end else if (need > CW'(STATES)) begin
          res_nxt.status = atm_pkg::ST_FULL;
          len_nxt        = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt   = '0;
          st_nxt    = '0;
          pb_re     = 1'b1;
          pb_raddr  = '0;
          state_nxt = S_CB_RD;
        end
      end
      S_CB_RD: begin
        // buffered byte is back, look up its edge
        b_nxt     = pb_rdata;
        tbl_re    = 1'b1;
        tbl_raddr = {st_r, pb_rdata};
        state_nxt = S_CT_EVAL;
      end
      S_CT_EVAL: begin
        if (tbl_empty) begin
          ent_nxt   = {idx_final, nf_r[SW-1:0]};
          tbl_we    = 1'b1;
          tbl_waddr = {st_r, atm_pkg::fold_lower(b_r)};
          tbl_wdata = {idx_final, nf_r[SW-1:0]};
          state_nxt = S_CT_WR2;
        end else begin
          st_nxt  = tbl_id;
          idx_nxt = idx_inc;
          if (idx_final) begin
            state_nxt = S_TAG_WR;
          end else begin
            pb_re     = 1'b1;
            pb_raddr  = idx_inc[BAW-1:0];
            state_nxt = S_CB_RD;
          end
        end
      end
      S_CT_WR2: begin
        tbl_we    = 1'b1;
        tbl_waddr = {st_r, atm_pkg::fold_upper(b_r)};
        tbl_wdata = ent_r;
        st_nxt    = nf_r[SW-1:0];
        nf_nxt    = nf_r + NFW'(1);
        idx_nxt   = idx_inc;
        if (idx_final) begin
          state_nxt = S_TAG_WR;
        end else begin
          pb_re     = 1'b1;
          pb_raddr  = idx_inc[BAW-1:0];
          state_nxt = S_CB_RD;
        end
      end
      S_TAG_WR: begin
        tg_we     = 1'b1;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        res_nxt   = '{status: atm_pkg::ST_ADDED, match_tag: 16'h0};
        state_nxt = S_EMIT;
      end
      S_SR_EVAL: begin
        res_nxt.match_tag = 16'h0;
        if (tbl_empty) begin
          dec_nxt        = 1'b1;
          res_nxt.status = atm_pkg::ST_NO_MATCH;
          state_nxt      = S_EMIT;
        end else begin
          walk_nxt = tbl_id;
          if (tbl_flag) begin
            dec_nxt   = 1'b1;
            tg_re     = 1'b1;
            state_nxt = S_SR_TAG;
          end else if (last_r) begin
            ss_nxt         = tbl_id;
            dec_nxt        = 1'b1;
            res_nxt.status = atm_pkg::ST_INCOMPLETE;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SR_TAG: begin
        res_nxt   = '{status: atm_pkg::ST_MATCH, match_tag: tg_rdata};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR_EMIT: begin
        if (out_free) begin
          out_push  = 1'b1;
          sweep_nxt = '0;
          state_nxt = S_SWEEP;
        end
      end
      default: begin
        state_nxt = S_SWEEP;
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      sweep_r <= '0;
      nf_r    <= NFW'(1);
      ss_r    <= '0;
      walk_r  <= '0;
      dec_r   <= 1'b0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      nf_r    <= nf_nxt;
      ss_r    <= ss_nxt;
      walk_r  <= walk_nxt;
      dec_r   <= dec_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    b_r    <= b_nxt;
    ent_r  <= ent_nxt;
    tag_r  <= tag_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

endmodule
